// ===== rtl/jvcir_pkg.sv =====
package jvcir_pkg;

  localparam int unsigned RepeatEntries = 33;

  localparam logic [2:0] CFG_HEADER_MARK  = 3'd0;
  localparam logic [2:0] CFG_HEADER_SPACE = 3'd1;
  localparam logic [2:0] CFG_BIT_MARK     = 3'd2;
  localparam logic [2:0] CFG_ONE_SPACE    = 3'd3;
  localparam logic [2:0] CFG_ZERO_SPACE   = 3'd4;
  localparam logic [2:0] CFG_MARK_EXCESS  = 3'd5;
  localparam logic [2:0] CFG_TOL_SHIFT    = 3'd6;

  localparam logic [1:0] ST_DECODED = 2'd0;
  localparam logic [1:0] ST_REPEAT  = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;

  typedef struct packed {
    logic [15:0] duration;
    logic        last_of_frame;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] value;
    logic [4:0]  bit_count;
  } out_t;

  typedef struct packed {
    logic [15:0] header_mark_ticks;
    logic [15:0] header_space_ticks;
    logic [15:0] bit_mark_ticks;
    logic [15:0] one_space_ticks;
    logic [15:0] zero_space_ticks;
    logic [7:0]  mark_excess_ticks;
    logic [2:0]  tolerance_shift;
  } cfg_t;

  // Classified word: window matches of one duration against every nominal.
  typedef struct packed {
    logic hdr_mark;
    logic hdr_space;
    logic bit_mark;
    logic one_space;
    logic zero_space;
    logic last;
  } cls_t;

  function automatic logic in_window(logic [15:0] dur, logic [15:0] nominal,
                                     logic [7:0] excess, logic [2:0] shift,
                                     logic is_mark);
    logic signed [18:0] adj;
    logic signed [18:0] tol;
    logic signed [18:0] meas;
    adj  = is_mark ? $signed({3'b000, nominal}) + $signed({11'b0, excess})
                   : $signed({3'b000, nominal}) - $signed({11'b0, excess});
    tol  = $signed({3'b000, nominal >> shift});
    meas = $signed({3'b000, dur});
    return (meas >= adj - tol) && (meas <= adj + tol);
  endfunction

endpackage

// ===== rtl/jvc_ir_frame_decoder_unit.sv =====
// JVC infrared frame decoder.
// Input channel (in_valid_i/in_ready_o/in_word_i): one measured duration per
// word, alternating mark and space from the first header mark; set
// last_of_frame on the final duration of a frame.
// Output channel (out_valid_o/out_ready_i/out_word_o): one result word per
// frame, posted for the word flagged last_of_frame: decoded value with its
// bit count, repeat code, or error.
// Configuration: write cfg_data_i to register cfg_idx_i while cfg_we_i is
// high; write only while the block is idle. Index 7 is ignored.
// Throughput: one duration per cycle, sustained while the output is not
// stalled, set by the window compare in the front stage and the update of
// the frame sequencer in the back stage.
// The result follows the last duration through the front register, then
// the queue, into the result register.
// Reset: registers take their nominal defaults and the frame state clears.
// Stall: a result waits in the output register; the back stage holds, the
// two-entry queue fills, and in_ready_o drops once the front stage is full.
module jvc_ir_frame_decoder_unit #(
  parameter int unsigned DATA_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  jvcir_pkg::in_t   in_word_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output jvcir_pkg::out_t  out_word_o
);

  logic            f_valid, f_ready;
  jvcir_pkg::cls_t f_word;
  logic            q_valid, q_pop;
  jvcir_pkg::cls_t q_word;

  jvcir_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .cls_valid_o (f_valid),
    .cls_ready_i (f_ready),
    .cls_word_o  (f_word)
  );

  jvcir_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (f_valid),
    .push_ready_o (f_ready),
    .push_word_i  (f_word),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_word_o   (q_word)
  );

  jvcir_back #(
    .DATA_BITS (DATA_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (q_valid),
    .cls_pop_o   (q_pop),
    .cls_word_i  (q_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== rtl/jvcir_front.sv =====
module jvcir_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  jvcir_pkg::in_t   in_word_i,
  output logic             cls_valid_o,
  input  logic             cls_ready_i,
  output jvcir_pkg::cls_t  cls_word_o
);

  jvcir_pkg::cfg_t cfg_q;
  jvcir_pkg::cls_t cls_d, cls_q;
  logic            valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_mark_ticks  <= 16'd160;
      cfg_q.header_space_ticks <= 16'd80;
      cfg_q.bit_mark_ticks     <= 16'd12;
      cfg_q.one_space_ticks    <= 16'd32;
      cfg_q.zero_space_ticks   <= 16'd11;
      cfg_q.mark_excess_ticks  <= 8'd2;
      cfg_q.tolerance_shift    <= 3'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jvcir_pkg::CFG_HEADER_MARK:  cfg_q.header_mark_ticks  <= cfg_data_i;
        jvcir_pkg::CFG_HEADER_SPACE: cfg_q.header_space_ticks <= cfg_data_i;
        jvcir_pkg::CFG_BIT_MARK:     cfg_q.bit_mark_ticks     <= cfg_data_i;
        jvcir_pkg::CFG_ONE_SPACE:    cfg_q.one_space_ticks    <= cfg_data_i;
        jvcir_pkg::CFG_ZERO_SPACE:   cfg_q.zero_space_ticks   <= cfg_data_i;
        jvcir_pkg::CFG_MARK_EXCESS:  cfg_q.mark_excess_ticks  <= cfg_data_i[7:0];
        jvcir_pkg::CFG_TOL_SHIFT:    cfg_q.tolerance_shift    <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cls_d.hdr_mark   = jvcir_pkg::in_window(in_word_i.duration, cfg_q.header_mark_ticks,
                         cfg_q.mark_excess_ticks, cfg_q.tolerance_shift, 1'b1);
    cls_d.hdr_space  = jvcir_pkg::in_window(in_word_i.duration, cfg_q.header_space_ticks,
                         cfg_q.mark_excess_ticks, cfg_q.tolerance_shift, 1'b0);
    cls_d.bit_mark   = jvcir_pkg::in_window(in_word_i.duration, cfg_q.bit_mark_ticks,
                         cfg_q.mark_excess_ticks, cfg_q.tolerance_shift, 1'b1);
    cls_d.one_space  = jvcir_pkg::in_window(in_word_i.duration, cfg_q.one_space_ticks,
                         cfg_q.mark_excess_ticks, cfg_q.tolerance_shift, 1'b0);
    cls_d.zero_space = jvcir_pkg::in_window(in_word_i.duration, cfg_q.zero_space_ticks,
                         cfg_q.mark_excess_ticks, cfg_q.tolerance_shift, 1'b0);
    cls_d.last       = in_word_i.last_of_frame;
  end

  assign in_ready_o  = !valid_q || cls_ready_i;
  assign cls_valid_o = valid_q;
  assign cls_word_o  = cls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cls_q <= cls_d;
    end
  end

endmodule

// ===== rtl/jvcir_fifo.sv =====
module jvcir_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             push_ready_o,
  input  jvcir_pkg::cls_t  push_word_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output jvcir_pkg::cls_t  pop_word_o
);

  jvcir_pkg::cls_t mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_word_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q)) else $error("queue pointers out of step");
`endif

endmodule

// ===== rtl/jvcir_back.sv =====
module jvcir_back #(
  parameter int unsigned DATA_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cls_valid_i,
  output logic             cls_pop_o,
  input  jvcir_pkg::cls_t  cls_word_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output jvcir_pkg::out_t  out_word_o
);

  localparam int unsigned StopPos = 2 * DATA_BITS + 2;
  localparam int unsigned PosW    = $clog2(StopPos + 2);
  localparam int unsigned CntW    = (PosW > 6) ? PosW + 1 : 7;

  logic [PosW-1:0]      pos_q, pos_d;
  logic [DATA_BITS-1:0] shift_q, shift_d;
  logic                 fail_q, fail_d;
  logic                 first_bm_q, first_bm_d;
  logic                 stop_q, stop_d;
  logic                 out_valid_q;
  jvcir_pkg::out_t      out_q, out_d;
  logic                 take;
  logic [CntW-1:0]      count;

  assign take      = cls_valid_i && (!out_valid_q || out_ready_i);
  assign cls_pop_o = take;
  assign count     = CntW'(pos_q) + CntW'(1);

  always_comb begin
    pos_d      = pos_q;
    shift_d    = shift_q;
    fail_d     = fail_q;
    first_bm_d = first_bm_q;
    stop_d     = stop_q;
    if (pos_q == '0) begin
      first_bm_d = cls_word_i.bit_mark;
      if (!cls_word_i.hdr_mark) fail_d = 1'b1;
    end else if (pos_q == PosW'(1)) begin
      if (!cls_word_i.hdr_space) fail_d = 1'b1;
    end else if (pos_q < PosW'(StopPos)) begin
      // even positions are bit marks, odd ones carry the data space
      if (!pos_q[0]) begin
        if (!cls_word_i.bit_mark) fail_d = 1'b1;
      end else if (cls_word_i.one_space) begin
        shift_d = (shift_q << 1) | DATA_BITS'(1);
      end else if (cls_word_i.zero_space) begin
        shift_d = shift_q << 1;
      end else begin
        fail_d = 1'b1;
      end
    end else if (pos_q == PosW'(StopPos)) begin
      if (cls_word_i.bit_mark) stop_d = 1'b1;
      else                     fail_d = 1'b1;
    end
    if (pos_q <= PosW'(StopPos)) pos_d = pos_q + PosW'(1);

    out_d.status    = jvcir_pkg::ST_DECODED;
    out_d.value     = 16'(shift_d);
    out_d.bit_count = 5'(DATA_BITS);
    if (count == CntW'(jvcir_pkg::RepeatEntries) && first_bm_q && cls_word_i.bit_mark) begin
      out_d.status    = jvcir_pkg::ST_REPEAT;
      out_d.value     = '0;
      out_d.bit_count = '0;
    end else if (fail_d || !stop_d) begin
      out_d.status    = jvcir_pkg::ST_ERROR;
      out_d.value     = '0;
      out_d.bit_count = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      shift_q     <= '0;
      fail_q      <= 1'b0;
      first_bm_q  <= 1'b0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) out_valid_q <= 1'b0;
      if (take) begin
        if (cls_word_i.last) begin
          // frame done: post the result and clear for the next one
          out_valid_q <= 1'b1;
          pos_q       <= '0;
          shift_q     <= '0;
          fail_q      <= 1'b0;
          first_bm_q  <= 1'b0;
          stop_q      <= 1'b0;
        end else begin
          pos_q       <= pos_d;
          shift_q     <= shift_d;
          fail_q      <= fail_d;
          first_bm_q  <= first_bm_d;
          stop_q      <= stop_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && cls_word_i.last) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(StopPos + 1)) else $error("entry position past saturation");
  a_last_posts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && cls_word_i.last) |=> (out_valid_q && pos_q == '0))
    else $error("last word did not post a result");
  a_stop_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |-> (pos_q == PosW'(StopPos + 1))) else $error("stop flag without stop mark");
`endif

endmodule
